// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DATA_W          = 32;
    localparam int FILL_W          = 5;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } t_spq_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [1:0]               status;
        logic [FILL_W-1:0]        fill_count;
    } t_spq_out;

endpackage

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Bounded priority queue held as a sorted circular buffer in one memory of
// QUEUE_DEPTH entries (value and priority side by side), highest priority at
// the head. Each request gives one result. A remove reads the head entry and
// advances the head pointer. An insert walks from the tail toward the head
// with one shared priority comparator, one memory read and one write per
// stored entry that has to move down; the entries that move are the stored
// entries of strictly lower priority than the new one, and the new entry
// may land at the head. A rejected request (remove from an empty queue,
// insert into a full queue) goes straight to the output state. Each request
// stays busy longer while the previous result still waits in the output
// register. The memory read port is the limit: each moved entry needs a
// registered read before its write. After the work the result goes into an
// output register, and the next request is taken while that result still
// waits. The memory needs no clearing after reset since only stored slots
// are ever read.
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spq_pkg::t_spq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spq_pkg::t_spq_out o_out_data
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(2 * QUEUE_DEPTH);
    localparam int MW = 2 * DATA_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_PUT  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_head,  n_head;
    logic [CW-1:0]            r_k,     n_k;
    logic                     r_is_rm, n_is_rm;
    logic signed [DATA_W-1:0] r_val,   n_val;
    logic signed [DATA_W-1:0] r_pri,   n_pri;
    t_spq_out                 r_res,   n_res;
    t_spq_out                 r_out,   n_out;
    logic                     r_out_valid, n_out_valid;
    logic [MW-1:0]            r_rd_data;
    logic [MW-1:0]            r_mem [QUEUE_DEPTH];

    logic [CW-1:0]            w_off;
    logic [SW-1:0]            w_sum;
    logic [AW-1:0]            w_addr;
    logic                     w_wr_en;
    logic [MW-1:0]            w_wr_data;
    logic                     w_keep;
    logic                     w_in_xfer;
    logic                     w_out_xfer;

    function automatic logic [FILL_W-1:0] fill_of(input logic [CW-1:0] c);
        logic [CW+FILL_W-1:0] e;
        e = {{FILL_W{1'b0}}, c};
        return e[FILL_W-1:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = r_out_valid && i_out_ready;

    // shared circular address unit: read one slot above k, write at k
    always_comb begin
        w_off  = (r_state == S_RD) ? (r_k - CW'(1)) : r_k;
        w_sum  = SW'(r_head) + SW'(w_off);
        w_addr = (w_sum >= DEPTH_S) ? AW'(w_sum - DEPTH_S) : AW'(w_sum);
    end

    // shared priority comparator: stored entry stays ahead of the new one
    assign w_keep = ($signed(r_rd_data[MW-1:DATA_W]) >= r_pri);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_k         = r_k;
        n_is_rm     = r_is_rm;
        n_val       = r_val;
        n_pri       = r_pri;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;
        w_wr_data   = {r_pri, r_val};

        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_is_rm = (i_in_data.req_type == REQ_REMOVE);
                    n_val   = i_in_data.item_value;
                    n_pri   = i_in_data.item_priority;
                    if (i_in_data.req_type == REQ_REMOVE) begin
                        if (r_count == '0) begin
                            n_res   = '{out_value: '0, status: ST_EMPTY,
                                        fill_count: fill_of(r_count)};
                            n_state = S_OUT;
                        end else begin
                            n_k     = CW'(1);
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_count == DEPTH_C) begin
                            n_res   = '{out_value: '0, status: ST_FULL,
                                        fill_count: fill_of(r_count)};
                            n_state = S_OUT;
                        end else if (r_count == '0) begin
                            n_k     = '0;
                            n_state = S_PUT;
                        end else begin
                            n_k     = r_count;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_is_rm) begin
                    n_count = r_count - CW'(1);
                    n_head  = w_addr;
                    n_res   = '{out_value: $signed(r_rd_data[DATA_W-1:0]),
                                status: ST_OK, fill_count: fill_of(r_count - CW'(1))};
                    n_state = S_OUT;
                end else if (w_keep) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CW'(1);
                    n_res   = '{out_value: '0, status: ST_OK,
                                fill_count: fill_of(r_count + CW'(1))};
                    n_state = S_OUT;
                end else begin
                    // entry of lower priority moves one slot toward the tail
                    w_wr_en   = 1'b1;
                    w_wr_data = r_rd_data;
                    n_k       = r_k - CW'(1);
                    n_state   = (r_k == CW'(1)) ? S_PUT : S_RD;
                end
            end
            S_PUT: begin
                w_wr_en = 1'b1;
                n_count = r_count + CW'(1);
                n_res   = '{out_value: '0, status: ST_OK,
                            fill_count: fill_of(r_count + CW'(1))};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_is_rm <= n_is_rm;
        r_val   <= n_val;
        r_pri   <= n_pri;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above queue depth");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready)
        else $error("request taken while previous one in progress");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_k != '0 && r_k <= r_count))
        else $error("read outside stored entries");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_EMPTY) |->
            (o_out_data.fill_count == '0 && o_out_data.out_value == '0))
        else $error("empty status with nonzero payload");

endmodule
